FILE: hw/rtl/rpv_pkg.sv
// Shared types, widths and register codes for the profile revolve block.
// No dependencies; every other rpv module imports this package.
`timescale 1ns / 1ps

package rpv_pkg;

   localparam int MAX_CUTS_DEF     = 64;
   localparam int SINE_ENTRIES_DEF = 1024;

   localparam int COORD_WIDTH     = 16;
   localparam int INDEX_WIDTH     = 8;
   localparam int VERTEX_WIDTH    = 14;
   localparam int CUT_WIDTH       = 7;
   localparam int STEP_WIDTH      = 16;
   localparam int STRIDE_WIDTH    = 9;
   localparam int SINE_WIDTH      = 15;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_PTR_WIDTH = 2;

   localparam logic [CUT_WIDTH-1:0]    NUM_CUTS_RESET    = 7'd16;
   localparam logic [STEP_WIDTH-1:0]   ANGLE_STEP_RESET  = 16'd4096;
   localparam logic [STRIDE_WIDTH-1:0] PROFILE_LEN_RESET = 9'd16;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_NUM_CUTS    = 2'd0,
      CSR_ANGLE_STEP  = 2'd1,
      CSR_PROFILE_LEN = 2'd2
   } csr_reg_type;

   typedef struct packed {
      logic [CUT_WIDTH-1:0]    num_cuts;
      logic [STEP_WIDTH-1:0]   angle_step;
      logic [STRIDE_WIDTH-1:0] profile_len;
   } cfg_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] pos_x;
      logic signed [COORD_WIDTH-1:0] pos_y;
      logic signed [COORD_WIDTH-1:0] pos_z;
      logic [INDEX_WIDTH-1:0]        point_index;
      logic [CUT_WIDTH-1:0]          num_cuts;
   } item_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] pos_x;
      logic signed [COORD_WIDTH-1:0] pos_y;
      logic signed [COORD_WIDTH-1:0] pos_z;
      logic [VERTEX_WIDTH-1:0]       vertex_index;
      logic                          last_copy;
   } cut_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] cos_val;
      logic signed [COORD_WIDTH-1:0] sin_val;
   } trig_type;

endpackage

FILE: hw/rtl/rpv_queue.sv
// Small item queue between the front and back parts.
// Depends on rpv_pkg for item_type and the queue depth.
`timescale 1ns / 1ps

module rpv_queue
   import rpv_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   input  logic     pop,
   output logic     head_valid,
   output item_type head_item,
   output logic     full
);

   item_type                   slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_WIDTH:0]   count_ff, count_in;

   assign head_valid = (count_ff != '0);
   assign full       = (count_ff == (QUEUE_PTR_WIDTH+1)'(QUEUE_DEPTH));
   assign head_item  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

FILE: hw/rtl/rpv_front.sv
// Front part: accepts profile points, resolves the cut count, queues them.
// Depends on rpv_pkg and rpv_queue.
`timescale 1ns / 1ps

module rpv_front
   import rpv_pkg::*;
#(
   parameter int MAX_CUTS = MAX_CUTS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cfg_type                       cfg,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_WIDTH-1:0] req_pos_x,
   input  logic signed [COORD_WIDTH-1:0] req_pos_y,
   input  logic signed [COORD_WIDTH-1:0] req_pos_z,
   input  logic [INDEX_WIDTH-1:0]        req_point_index,
   output logic                          head_valid,
   output item_type                      head_item,
   input  logic                          head_pop
);

   localparam logic [CUT_WIDTH-1:0] CUT_MAX = CUT_WIDTH'(MAX_CUTS);
   localparam logic [CUT_WIDTH-1:0] CUT_ONE = CUT_WIDTH'(1);

   logic     full;
   logic     push;
   item_type push_item;

   assign req_stall = full;
   assign push      = req_valid && !full;

   always_comb begin
      push_item.pos_x       = req_pos_x;
      push_item.pos_y       = req_pos_y;
      push_item.pos_z       = req_pos_z;
      push_item.point_index = req_point_index;
      if (cfg.num_cuts == '0) begin
         push_item.num_cuts = CUT_ONE;
      end else if (cfg.num_cuts > CUT_MAX) begin
         push_item.num_cuts = CUT_MAX;
      end else begin
         push_item.num_cuts = cfg.num_cuts;
      end
   end

   rpv_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .pop        (head_pop),
      .head_valid (head_valid),
      .head_item  (head_item),
      .full       (full)
   );

endmodule

FILE: hw/rtl/rpv_trig.sv
// Phase to cosine/sine pipeline: table index, quadrant fold, sine table read.
// Depends on rpv_pkg; the quarter-wave table is built at elaboration.
`timescale 1ns / 1ps

module rpv_trig
   import rpv_pkg::*;
#(
   parameter int SINE_ENTRIES = SINE_ENTRIES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic [STEP_WIDTH-1:0] in_phase,
   input  cut_type               in_cut,
   output logic                  out_valid,
   output cut_type               out_cut,
   output trig_type              out_trig
);

   localparam int KW = $clog2(SINE_ENTRIES);
   localparam int RW = $clog2(SINE_ENTRIES + 1);
   localparam int UW = KW + 2;
   localparam int PW = STEP_WIDTH + RW;

   localparam logic [UW-1:0] SE_1 = UW'(SINE_ENTRIES);
   localparam logic [UW-1:0] SE_2 = UW'(2 * SINE_ENTRIES);
   localparam logic [UW-1:0] SE_3 = UW'(3 * SINE_ENTRIES);
   localparam logic [RW-1:0] SE_R = RW'(SINE_ENTRIES);
   localparam logic [PW-1:0] SE_P = PW'(SINE_ENTRIES);

   localparam logic [63:0] Q30_ONE     = 64'd1073741824;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] Q14_ONE     = 64'd16384;

   typedef enum logic [1:0] {QUAD_0, QUAD_1, QUAD_2, QUAD_3} quad_type;

   function automatic logic [SINE_WIDTH-1:0] quarter_sine(input int unsigned n);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      x  = (64'(n) * HALF_PI_Q30) / 64'(SINE_ENTRIES);
      x2 = (x * x) >> 30;
      t  = Q30_ONE - x2 / 64'd72;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
      t  = (x * t) >> 30;
      t  = (t + 64'd32768) >> 16;
      if (t > Q14_ONE) begin
         t = Q14_ONE;
      end
      return t[SINE_WIDTH-1:0];
   endfunction

   logic [SINE_WIDTH-1:0] sine_rom [0:SINE_ENTRIES];

   for (genvar g = 0; g <= SINE_ENTRIES; g++) begin : g_rom
      assign sine_rom[g] = quarter_sine(g);
   end

   logic                  valid1_ff, valid2_ff, valid3_ff;
   cut_type               cut1_ff, cut2_ff, cut3_ff;
   logic [KW-1:0]         k1_ff;
   logic [RW-1:0]         rem_s2_ff, rem_c2_ff;
   quad_type              quad2_ff, quad3_ff;
   logic [SINE_WIDTH-1:0] s0_3_ff, c0_3_ff;

   logic [PW-1:0]         phase_prod;
   logic [KW-1:0]         k1_in;
   logic [UW-1:0]         u2, base2, rem_full2;
   quad_type              quad2_in;
   logic [RW-1:0]         rem_s2_in, rem_c2_in;
   logic signed [COORD_WIDTH-1:0] s0_sgn, c0_sgn;

   always_comb begin
      phase_prod = PW'(in_phase) * SE_P;
      k1_in      = phase_prod[STEP_WIDTH +: KW];
   end

   always_comb begin
      u2 = {k1_ff, 2'b00};
      if (u2 >= SE_3) begin
         quad2_in = QUAD_3;
         base2    = SE_3;
      end else if (u2 >= SE_2) begin
         quad2_in = QUAD_2;
         base2    = SE_2;
      end else if (u2 >= SE_1) begin
         quad2_in = QUAD_1;
         base2    = SE_1;
      end else begin
         quad2_in = QUAD_0;
         base2    = '0;
      end
      rem_full2 = u2 - base2;
      rem_s2_in = rem_full2[RW-1:0];
      rem_c2_in = SE_R - rem_full2[RW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else if (en) begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
         valid3_ff <= valid2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cut1_ff   <= in_cut;
         k1_ff     <= k1_in;
         cut2_ff   <= cut1_ff;
         quad2_ff  <= quad2_in;
         rem_s2_ff <= rem_s2_in;
         rem_c2_ff <= rem_c2_in;
         cut3_ff   <= cut2_ff;
         quad3_ff  <= quad2_ff;
         s0_3_ff   <= sine_rom[rem_s2_ff];
         c0_3_ff   <= sine_rom[rem_c2_ff];
      end
   end

   assign s0_sgn    = signed'({1'b0, s0_3_ff});
   assign c0_sgn    = signed'({1'b0, c0_3_ff});
   assign out_valid = valid3_ff;
   assign out_cut   = cut3_ff;

   always_comb begin
      unique case (quad3_ff)
         QUAD_0: begin
            out_trig.sin_val = s0_sgn;
            out_trig.cos_val = c0_sgn;
         end
         QUAD_1: begin
            out_trig.sin_val = c0_sgn;
            out_trig.cos_val = -s0_sgn;
         end
         QUAD_2: begin
            out_trig.sin_val = -s0_sgn;
            out_trig.cos_val = -c0_sgn;
         end
         QUAD_3: begin
            out_trig.sin_val = -c0_sgn;
            out_trig.cos_val = s0_sgn;
         end
         default: begin
            out_trig.sin_val = s0_sgn;
            out_trig.cos_val = c0_sgn;
         end
      endcase
   end

endmodule

FILE: hw/rtl/rpv_back.sv
// Back part: cut sequencer, rotation multipliers, rounding and result register.
// Depends on rpv_pkg and rpv_trig.
`timescale 1ns / 1ps

module rpv_back
   import rpv_pkg::*;
#(
   parameter int SINE_ENTRIES = SINE_ENTRIES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cfg_type                       cfg,
   input  logic                          head_valid,
   input  item_type                      head_item,
   output logic                          head_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [COORD_WIDTH-1:0] rsp_out_x,
   output logic signed [COORD_WIDTH-1:0] rsp_out_y,
   output logic signed [COORD_WIDTH-1:0] rsp_out_z,
   output logic [VERTEX_WIDTH-1:0]       rsp_vertex_index,
   output logic                          rsp_last_copy
);

   localparam int PRW = 2 * COORD_WIDTH;
   localparam int SW  = PRW + 1;

   function automatic logic signed [COORD_WIDTH-1:0] round_sat(
      input logic signed [SW-1:0] sum
   );
      logic signed [SW-1:0] biased;
      logic signed [18:0]   r;
      biased = sum + SW'(8192);
      r      = 19'(biased >>> 14);
      if (r > 19'sd32767) begin
         return 16'sh7FFF;
      end else if (r < -19'sd32768) begin
         return 16'sh8000;
      end
      return r[COORD_WIDTH-1:0];
   endfunction

   logic                    en;
   logic                    issue;
   logic                    first;
   logic                    last;
   logic [CUT_WIDTH-1:0]    cut_ff, cut_in;
   logic [STEP_WIDTH-1:0]   phase_ff, phase_in, phase_cur;
   logic [VERTEX_WIDTH-1:0] vidx_ff, vidx_in, vidx_cur;
   cut_type                 issue_cut;

   logic     trig_valid;
   cut_type  trig_cut;
   trig_type trig;

   logic                  valid4_ff;
   cut_type               cut4_ff;
   logic signed [PRW-1:0] xc_ff, zs_ff, zc_ff, xs_ff;
   logic signed [SW-1:0]  sum_x, sum_z;

   logic                          rsp_valid_ff;
   logic signed [COORD_WIDTH-1:0] out_x_ff, out_y_ff, out_z_ff;
   logic [VERTEX_WIDTH-1:0]       vidx_out_ff;
   logic                          last_out_ff;

   assign en       = !(rsp_valid_ff && rsp_stall);
   assign issue    = en && head_valid;
   assign first    = (cut_ff == '0);
   assign last     = ((cut_ff + 1'b1) == head_item.num_cuts);
   assign head_pop = issue && last;

   always_comb begin
      phase_cur = first ? '0 : phase_ff;
      vidx_cur  = first ? VERTEX_WIDTH'(head_item.point_index) : vidx_ff;
      phase_in  = phase_cur + cfg.angle_step;
      vidx_in   = vidx_cur + VERTEX_WIDTH'(cfg.profile_len);
      cut_in    = last ? '0 : cut_ff + 1'b1;

      issue_cut.pos_x        = head_item.pos_x;
      issue_cut.pos_y        = head_item.pos_y;
      issue_cut.pos_z        = head_item.pos_z;
      issue_cut.vertex_index = vidx_cur;
      issue_cut.last_copy    = last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cut_ff <= '0;
      end else if (issue) begin
         cut_ff <= cut_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         phase_ff <= phase_in;
         vidx_ff  <= vidx_in;
      end
   end

   rpv_trig #(
      .SINE_ENTRIES (SINE_ENTRIES)
   ) u_trig (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (head_valid),
      .in_phase  (phase_cur),
      .in_cut    (issue_cut),
      .out_valid (trig_valid),
      .out_cut   (trig_cut),
      .out_trig  (trig)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid4_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         valid4_ff    <= trig_valid;
         rsp_valid_ff <= valid4_ff;
      end
   end

   assign sum_x = SW'(xc_ff) + SW'(zs_ff);
   assign sum_z = SW'(zc_ff) - SW'(xs_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         cut4_ff     <= trig_cut;
         xc_ff       <= trig_cut.pos_x * trig.cos_val;
         zs_ff       <= trig_cut.pos_z * trig.sin_val;
         zc_ff       <= trig_cut.pos_z * trig.cos_val;
         xs_ff       <= trig_cut.pos_x * trig.sin_val;
         out_x_ff    <= round_sat(sum_x);
         out_z_ff    <= round_sat(sum_z);
         out_y_ff    <= cut4_ff.pos_y;
         vidx_out_ff <= cut4_ff.vertex_index;
         last_out_ff <= cut4_ff.last_copy;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_x        = out_x_ff;
   assign rsp_out_y        = out_y_ff;
   assign rsp_out_z        = out_z_ff;
   assign rsp_vertex_index = vidx_out_ff;
   assign rsp_last_copy    = last_out_ff;

endmodule

FILE: hw/rtl/revolve_profile_vertices.sv
// Each accepted profile point yields num_cuts rotated copies (0 acts as 1, values above
// MAX_CUTS act as MAX_CUTS), one result per cycle while the output is not stalled; the cut
// sequencer issuing one cut per cycle sets that rate, and back-to-back points follow
// without a gap. A four-item queue decouples input from the sequencer, and each cut
// passes the table-index, quadrant, table-read, product and result registers before it
// is presented. Sine values come from a quarter-wave table of SINE_ENTRIES+1 entries
// built at elaboration; no warm-up pass. Depends on rpv_pkg, rpv_front and rpv_back.
`timescale 1ns / 1ps

module revolve_profile_vertices
   import rpv_pkg::*;
#(
   parameter int MAX_CUTS     = MAX_CUTS_DEF,
   parameter int SINE_ENTRIES = SINE_ENTRIES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_WIDTH-1:0] req_pos_x,
   input  logic signed [COORD_WIDTH-1:0] req_pos_y,
   input  logic signed [COORD_WIDTH-1:0] req_pos_z,
   input  logic [INDEX_WIDTH-1:0]        req_point_index,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [COORD_WIDTH-1:0] rsp_out_x,
   output logic signed [COORD_WIDTH-1:0] rsp_out_y,
   output logic signed [COORD_WIDTH-1:0] rsp_out_z,
   output logic [VERTEX_WIDTH-1:0]       rsp_vertex_index,
   output logic                          rsp_last_copy,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]     csr_data
);

   logic [CUT_WIDTH-1:0]    num_cuts_ff;
   logic [STEP_WIDTH-1:0]   angle_step_ff;
   logic [STRIDE_WIDTH-1:0] profile_len_ff;
   cfg_type                 cfg;

   logic     head_valid;
   item_type head_item;
   logic     head_pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_cuts_ff    <= NUM_CUTS_RESET;
         angle_step_ff  <= ANGLE_STEP_RESET;
         profile_len_ff <= PROFILE_LEN_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_NUM_CUTS:    num_cuts_ff    <= csr_data[CUT_WIDTH-1:0];
            CSR_ANGLE_STEP:  angle_step_ff  <= csr_data[STEP_WIDTH-1:0];
            CSR_PROFILE_LEN: profile_len_ff <= csr_data[STRIDE_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      cfg.num_cuts    = num_cuts_ff;
      cfg.angle_step  = angle_step_ff;
      cfg.profile_len = profile_len_ff;
   end

   rpv_front #(
      .MAX_CUTS (MAX_CUTS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_pos_z       (req_pos_z),
      .req_point_index (req_point_index),
      .head_valid      (head_valid),
      .head_item       (head_item),
      .head_pop        (head_pop)
   );

   rpv_back #(
      .SINE_ENTRIES (SINE_ENTRIES)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .head_valid       (head_valid),
      .head_item        (head_item),
      .head_pop         (head_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_x        (rsp_out_x),
      .rsp_out_y        (rsp_out_y),
      .rsp_out_z        (rsp_out_z),
      .rsp_vertex_index (rsp_vertex_index),
      .rsp_last_copy    (rsp_last_copy)
   );

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("results or queue not cleared by reset");

   a_pop_needs_item: assert property (@(posedge clock) disable iff (reset)
      head_pop |-> head_valid)
      else $error("queue popped while empty");

   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> !head_pop)
      else $error("sequencer advanced while result held");

endmodule

FILE: test/rpv_vertex_checker.sv
// Vertex checker for revolve_profile_vertices: tracks register writes, predicts the
// rotated copies of every accepted profile point and compares each result in order.
// Depends on rpv_pkg for widths, register codes and the register struct.
`timescale 1ns / 1ps

module rpv_vertex_checker
   import rpv_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic signed [COORD_WIDTH-1:0] req_pos_x,
   input  logic signed [COORD_WIDTH-1:0] req_pos_y,
   input  logic signed [COORD_WIDTH-1:0] req_pos_z,
   input  logic [INDEX_WIDTH-1:0]        req_point_index,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic signed [COORD_WIDTH-1:0] rsp_out_x,
   input  logic signed [COORD_WIDTH-1:0] rsp_out_y,
   input  logic signed [COORD_WIDTH-1:0] rsp_out_z,
   input  logic [VERTEX_WIDTH-1:0]       rsp_vertex_index,
   input  logic                          rsp_last_copy,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]     csr_data,
   output int                            fail_count,
   output int                            pending,
   output int                            vertices_checked
);

   localparam longint unsigned Q30_ONE     = 64'd1 << 30;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam longint unsigned SINE_STEPS  = SINE_ENTRIES_DEF;
   localparam longint unsigned UNIT_Q14    = 64'd16384;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] out_x;
      logic signed [COORD_WIDTH-1:0] out_y;
      logic signed [COORD_WIDTH-1:0] out_z;
      logic [VERTEX_WIDTH-1:0]       vertex_index;
      logic                          last_copy;
   } vertex_type;

   cfg_type    cfg;
   vertex_type expected_vertices[$];

   // sin(n/SINE_STEPS * pi/2) in Q14 from a truncating Q30 Taylor series
   function automatic longint quarter_sine_q14(input longint unsigned n);
      longint unsigned arg, arg2, acc;
      if (n > SINE_STEPS) n = SINE_STEPS;
      arg  = n * HALF_PI_Q30 / SINE_STEPS;
      arg2 = (arg * arg) >> 30;
      acc  = Q30_ONE - arg2 / 72;
      acc  = Q30_ONE - ((arg2 * acc) >> 30) / 42;
      acc  = Q30_ONE - ((arg2 * acc) >> 30) / 20;
      acc  = Q30_ONE - ((arg2 * acc) >> 30) / 6;
      acc  = (arg * acc) >> 30;
      acc  = (acc + 32768) >> 16;
      if (acc > UNIT_Q14) acc = UNIT_Q14;
      return longint'(acc);
   endfunction

   function automatic void cut_rotation(input logic [STEP_WIDTH-1:0] phase,
                                        output longint cos_q14, output longint sin_q14);
      longint unsigned slot, quad, rem;
      longint s0, c0;
      slot = ({48'd0, phase} * SINE_STEPS) >> 16;
      quad = (slot * 4 / SINE_STEPS) & 3;
      rem  = (slot * 4) % SINE_STEPS;
      s0   = quarter_sine_q14(rem);
      c0   = quarter_sine_q14(SINE_STEPS - rem);
      case (quad)
         0: begin
            cos_q14 = c0;
            sin_q14 = s0;
         end
         1: begin
            cos_q14 = -s0;
            sin_q14 = c0;
         end
         2: begin
            cos_q14 = -c0;
            sin_q14 = -s0;
         end
         default: begin
            cos_q14 = s0;
            sin_q14 = -c0;
         end
      endcase
   endfunction

   function automatic logic [COORD_WIDTH-1:0] q12_saturate(input longint acc);
      longint rounded;
      rounded = (acc + 8192) >>> 14;
      if (rounded > 32767) rounded = 32767;
      else if (rounded < -32768) rounded = -32768;
      return rounded[COORD_WIDTH-1:0];
   endfunction

   task automatic check_field(input string field, input longint want, input longint got);
      if (want != got) begin
         $display("%0t %s mismatch: expected %0d, got %0d", $time, field, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      vertex_type want, fresh;
      longint px, pz, c, s;
      int copies;
      if (reset) begin
         cfg.num_cuts    = NUM_CUTS_RESET;
         cfg.angle_step  = ANGLE_STEP_RESET;
         cfg.profile_len = PROFILE_LEN_RESET;
         expected_vertices.delete();
         fail_count       = 0;
         vertices_checked = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_NUM_CUTS:    cfg.num_cuts    = csr_data[CUT_WIDTH-1:0];
               CSR_ANGLE_STEP:  cfg.angle_step  = csr_data[STEP_WIDTH-1:0];
               CSR_PROFILE_LEN: cfg.profile_len = csr_data[STRIDE_WIDTH-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_vertices.size() == 0) begin
               $display("%0t unexpected vertex: index %0d, x %0d", $time,
                        rsp_vertex_index, rsp_out_x);
               fail_count++;
            end else begin
               want = expected_vertices.pop_front();
               check_field("out_x", $signed(want.out_x), rsp_out_x);
               check_field("out_y", $signed(want.out_y), rsp_out_y);
               check_field("out_z", $signed(want.out_z), rsp_out_z);
               check_field("vertex_index", want.vertex_index, rsp_vertex_index);
               check_field("last_copy", want.last_copy, rsp_last_copy);
               vertices_checked++;
            end
         end
         if (req_valid && !req_stall) begin
            px     = req_pos_x;
            pz     = req_pos_z;
            copies = cfg.num_cuts;
            if (copies == 0) copies = 1;
            else if (copies > MAX_CUTS_DEF) copies = MAX_CUTS_DEF;
            for (int j = 0; j < copies; j++) begin
               cut_rotation(STEP_WIDTH'(j * cfg.angle_step), c, s);
               fresh.out_x        = q12_saturate(px * c + pz * s);
               fresh.out_y        = req_pos_y;
               fresh.out_z        = q12_saturate(pz * c - px * s);
               fresh.vertex_index = VERTEX_WIDTH'(req_point_index + j * cfg.profile_len);
               fresh.last_copy    = (j == copies - 1);
               expected_vertices.insert(expected_vertices.size(), fresh);
            end
         end
      end
      pending = expected_vertices.size();
   end

endmodule

FILE: test/testbench.sv
// Top of the revolve_profile_vertices testbench: clock, reset, point and register
// stimulus, receiver pacing, watchdog and verdict. Depends on rpv_pkg, the block
// and rpv_vertex_checker, which predicts and compares the vertex copies.
`timescale 1ns / 1ps

module testbench;
   import rpv_pkg::*;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE = 2'd3;
   localparam int HOLD_CYCLES   = 150;
   localparam int STALL_LIMIT   = 3000;
   localparam int SETTLE_CYCLES = 16;
   localparam int SEGMENT_ITEMS = 20;

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic signed [COORD_WIDTH-1:0] req_pos_x;
   logic signed [COORD_WIDTH-1:0] req_pos_y;
   logic signed [COORD_WIDTH-1:0] req_pos_z;
   logic [INDEX_WIDTH-1:0]        req_point_index;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic signed [COORD_WIDTH-1:0] rsp_out_x;
   logic signed [COORD_WIDTH-1:0] rsp_out_y;
   logic signed [COORD_WIDTH-1:0] rsp_out_z;
   logic [VERTEX_WIDTH-1:0]       rsp_vertex_index;
   logic                          rsp_last_copy;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [CSR_INDEX_WIDTH-1:0]    csr_index;
   logic [CSR_DATA_WIDTH-1:0]     csr_data;

   int fail_count;
   int pending;
   int vertices_checked;
   int snd_idle_pct = 0;
   int rcv_idle_pct = 0;
   int holds_asked  = 0;
   int holds_done   = 0;
   int points_sent  = 0;
   int reg_writes   = 0;
   int quiet_cycles = 0;

   always #5 clock = ~clock;

   revolve_profile_vertices dut (.*);

   rpv_vertex_checker vertex_check (.*);

   initial begin : receiver
      int held;
      held      = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_done < holds_asked) begin
            rsp_stall <= 1'b1;
            held++;
            if (held == HOLD_CYCLES) begin
               held = 0;
               holds_done++;
            end
         end else begin
            rsp_stall <= (rcv_idle_pct != 0) && ($urandom_range(99) < rcv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("timeout: no handshake for %0d cycles, %0d vertices outstanding",
                  STALL_LIMIT, pending);
         $display("[revolve_profile_vertices] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic signed [COORD_WIDTH-1:0] pick_coord();
      case ($urandom_range(7))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return COORD_WIDTH'($urandom_range(512)) - 16'sd256;
         default: return COORD_WIDTH'($urandom);
      endcase
   endfunction

   task automatic send_point(input logic signed [COORD_WIDTH-1:0] x, y, z,
                             input logic [INDEX_WIDTH-1:0] idx);
      csr_valid <= 1'b0;
      while ($urandom_range(99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_pos_x       <= x;
      req_pos_y       <= y;
      req_pos_z       <= z;
      req_point_index <= idx;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      points_sent++;
   endtask

   // drain all vertices first; valid stays up for a back-to-back write
   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      req_valid <= 1'b0;
      if (pending != 0) csr_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      reg_writes++;
   endtask

   task automatic run_segment(input bit long_hold);
      int cuts, stride, first;
      logic [CSR_DATA_WIDTH-1:0] step;
      logic [INDEX_WIDTH-1:0] idx;
      case ($urandom_range(9))
         0: cuts = 0;
         1: cuts = $urandom_range(127, 65);
         2: cuts = MAX_CUTS_DEF;
         3: cuts = 1;
         default: cuts = $urandom_range(24, 2);
      endcase
      if ($urandom_range(3) == 0) begin
         step = CSR_DATA_WIDTH'($urandom);
      end else begin
         step = CSR_DATA_WIDTH'(65536 / ((cuts == 0) ? 1 :
                                         (cuts > MAX_CUTS_DEF) ? MAX_CUTS_DEF : cuts));
      end
      case ($urandom_range(7))
         0: stride = 0;
         1: stride = $urandom_range(511, 257);
         default: stride = $urandom_range(256, 1);
      endcase
      write_reg(CSR_NUM_CUTS, {9'($urandom), 7'(cuts)});
      write_reg(CSR_ANGLE_STEP, step);
      write_reg(CSR_PROFILE_LEN, {7'($urandom), 9'(stride)});
      if ($urandom_range(4) == 0) write_reg(CSR_SPARE, CSR_DATA_WIDTH'($urandom));
      if (long_hold) holds_asked++;
      first = ($urandom_range(3) == 0) ? $urandom_range(255) : 0;
      for (int i = 0; i < SEGMENT_ITEMS; i++) begin
         if ($urandom_range(9) < 8) idx = INDEX_WIDTH'(first + i);
         else idx = INDEX_WIDTH'($urandom);
         send_point(pick_coord(), pick_coord(), pick_coord(), idx);
      end
   endtask

   initial begin : stimulus
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_pos_x       = '0;
      req_pos_y       = '0;
      req_pos_z       = '0;
      req_point_index = '0;
      csr_valid       = 1'b0;
      csr_index       = CSR_NUM_CUTS;
      csr_data        = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_point(16'sd0, 16'sd0, 16'sd0, 8'd0);
      send_point(16'sh7FFF, 16'sd0, 16'sd0, 8'd255);
      send_point(16'sh8000, 16'sh7FFF, 16'sd0, 8'd1);
      send_point(16'sd0, 16'sh8000, 16'sh7FFF, 8'd2);
      send_point(16'sd0, 16'sd1, 16'sh8000, 8'd3);
      send_point(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 8'd128);
      send_point(16'sh8000, 16'sh8000, 16'sh8000, 8'd127);
      send_point(16'sh7FFF, 16'shFFFF, 16'sh8000, 8'd85);
      send_point(16'sh5555, 16'shAAAA, 16'sh2AAA, 8'd170);
      // zero cut count gives a single copy
      write_reg(CSR_NUM_CUTS, 16'h0000);
      send_point(16'sd4096, 16'sd100, -16'sd4096, 8'd7);
      // excess cut count clamps to the maximum
      write_reg(CSR_NUM_CUTS, 16'hFFFF);
      write_reg(CSR_ANGLE_STEP, 16'd1024);
      send_point(16'sh7FFF, 16'sd5, -16'sd20000, 8'd255);
      // oversized and zero stride, point beyond profile
      write_reg(CSR_PROFILE_LEN, 16'hFFFF);
      send_point(-16'sd12345, 16'shFFFF, 16'sd23456, 8'd255);
      write_reg(CSR_PROFILE_LEN, 16'h0000);
      send_point(16'sd1, 16'sd2, 16'sd3, 8'd9);
      write_reg(CSR_ANGLE_STEP, 16'h0000);
      send_point(16'sh4000, 16'sh8000, -16'sh4000, 8'd200);
      write_reg(CSR_ANGLE_STEP, 16'hFFFF);
      send_point(16'sh8000, 16'sh7FFF, 16'sh7FFF, 8'd64);
      write_reg(CSR_SPARE, 16'h0001);
      send_point(16'sd1000, -16'sd1000, 16'sd2000, 8'd33);
      write_reg(CSR_NUM_CUTS, 16'd1);
      write_reg(CSR_ANGLE_STEP, 16'h8000);
      write_reg(CSR_PROFILE_LEN, 16'd256);
      send_point(16'sh7FFF, 16'sh0001, 16'sh8000, 8'd254);
      write_reg(CSR_NUM_CUTS, 16'd64);
      send_point(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 8'd255);

      snd_idle_pct = 27;
      rcv_idle_pct = 58;
      for (int seg = 0; seg < 5; seg++) run_segment(seg == 0);
      snd_idle_pct = 58;
      rcv_idle_pct = 27;
      for (int seg = 0; seg < 5; seg++) run_segment(seg == 0);
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      for (int seg = 0; seg < 5; seg++) run_segment(seg == 0);

      req_valid <= 1'b0;
      csr_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      $display("covered %0d points, %0d vertices compared, %0d register writes",
               points_sent, vertices_checked, reg_writes);
      $display("pacing: sender idle, receiver idle, back to back; %0d long receiver holds",
               holds_done);
      if (fail_count == 0 && pending == 0) begin
         $display("[revolve_profile_vertices] OK");
      end else begin
         $display("[revolve_profile_vertices] ERROR");
      end
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/rpv_pkg.sv
hw/rtl/rpv_queue.sv
hw/rtl/rpv_front.sv
hw/rtl/rpv_trig.sv
hw/rtl/rpv_back.sv
hw/rtl/revolve_profile_vertices.sv
test/rpv_vertex_checker.sv
test/testbench.sv
